// ===== design/ipv4_text_parse_classify_unit_defines.svh =====
// Assertion macros shared by the checker of the IPv4 text parse unit.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef IPV4_TEXT_PARSE_CLASSIFY_UNIT_DEFINES_SVH
`define IPV4_TEXT_PARSE_CLASSIFY_UNIT_DEFINES_SVH

// same-cycle implication, skipped while in reset
`define IPV4TP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipv4tp same-cycle check failed");

// next-cycle implication, skipped while in reset
`define IPV4TP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipv4tp next-cycle check failed");

`endif

// ===== design/ipv4tp_pkg.sv =====
// Types and constants of the IPv4 text parse unit.
// Used by ipv4tp_parse and the top level; depends on nothing.
`timescale 1ns / 1ps

package ipv4tp_pkg;

  localparam logic [7:0]  CH_DOT    = 8'h2E;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [11:0] OCTET_MAX = 12'd255;
  localparam logic [1:0]  LAST_IDX  = 2'd3;
  localparam logic [1:0]  MAX_DIGITS = 2'd3;

  localparam logic [31:0] NET10_BASE  = 32'h0A00_0000;
  localparam logic [31:0] NET10_MASK  = 32'hFF00_0000;
  localparam logic [31:0] NET172_BASE = 32'hAC10_0000;
  localparam logic [31:0] NET172_MASK = 32'hFFF0_0000;
  localparam logic [31:0] NET192_BASE = 32'hC0A8_0000;
  localparam logic [31:0] NET192_MASK = 32'hFFFF_0000;

  typedef struct packed {
    logic [1:0]  octet_index;
    logic [7:0]  octet_value;
    logic [1:0]  digit_count;
    logic [23:0] completed_octets;
    logic        failed;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    octet_index: 2'd0, octet_value: 8'd0, digit_count: 2'd0,
    completed_octets: 24'd0, failed: 1'b0};

  typedef struct packed {
    logic        is_valid;
    logic [31:0] address;
    logic        is_private;
  } result_t;

endpackage

// ===== design/ipv4tp_parse.sv =====
// Parse state registers and per-character update of the IPv4 text parse unit.
// Produces the closing result from the updated state; depends on ipv4tp_pkg.
`timescale 1ns / 1ps

module ipv4tp_parse import ipv4tp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] character,
  input  logic       no_character,
  input  logic       ends_string,
  output result_t    res
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  parse_state_t upd;
  logic         take;
  logic         is_digit;
  logic [3:0]   digit;
  logic [11:0]  digit_sum;
  logic         ok;
  logic [31:0]  addr;

  always_comb begin
    upd       = st_r;
    take      = !no_character && !st_r.failed;
    is_digit  = (character >= CH_ZERO) && (character <= CH_NINE);
    digit     = 4'(character - CH_ZERO);
    digit_sum = {1'b0, st_r.octet_value, 3'b000} + {3'b000, st_r.octet_value, 1'b0}
              + {8'd0, digit};
    if (take) begin
      if (is_digit) begin
        if (st_r.digit_count >= MAX_DIGITS || digit_sum > OCTET_MAX) begin
          upd.failed = 1'b1;
        end else begin
          upd.octet_value = digit_sum[7:0];
          upd.digit_count = st_r.digit_count + 2'd1;
        end
      end else if (character == CH_DOT) begin
        if (st_r.digit_count == 2'd0 || st_r.octet_index >= LAST_IDX) begin
          upd.failed = 1'b1;
        end else begin
          upd.completed_octets = {st_r.completed_octets[15:0], st_r.octet_value};
          upd.octet_index      = st_r.octet_index + 2'd1;
          upd.octet_value      = 8'd0;
          upd.digit_count      = 2'd0;
        end
      end else begin
        upd.failed = 1'b1;
      end
    end
  end

  always_comb begin
    ok   = !upd.failed && upd.octet_index == LAST_IDX && upd.digit_count != 2'd0;
    addr = ok ? {upd.completed_octets, upd.octet_value} : 32'd0;
    res.is_valid   = ok;
    res.address    = addr;
    res.is_private = ok && (((addr & NET10_MASK) == NET10_BASE)
                         || ((addr & NET172_MASK) == NET172_BASE)
                         || ((addr & NET192_MASK) == NET192_BASE));
  end

  always_comb begin
    st_nxt = st_r;
    if (step_en) begin
      st_nxt = ends_string ? PARSE_RESET : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= PARSE_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== design/ipv4_text_parse_classify_unit.sv =====
// Top level of the IPv4 dotted-quad text parser and private-range classifier.
// Instantiates ipv4tp_parse; depends on ipv4tp_pkg.
`timescale 1ns / 1ps
// Takes one ASCII character per word and gives one result word when a word
// marked ends_string arrives: is_valid, the 32-bit address and is_private.
// A new input word is taken every cycle while the input register is free to
// advance; a closing word passes from the input register to the result
// register, where its result is held. The parse state loop runs through a
// shift-and-add times ten and a compare, which sets the clock. While a result
// waits on out_ready, words that do not close a string keep flowing; a closing
// word holds in the input register until the result register frees.

module ipv4_text_parse_classify_unit import ipv4tp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_character,
  input  logic        in_no_character,
  input  logic        in_ends_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_is_valid,
  output logic [31:0] out_address,
  output logic        out_is_private
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_none_r;
  logic       s1_ends_r;
  logic       out_valid_r, out_valid_nxt;
  result_t    res_r;
  result_t    res;
  logic       out_free;
  logic       s1_adv;
  logic       in_fire;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_ends_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  ipv4tp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_adv),
    .character    (s1_char_r),
    .no_character (s1_none_r),
    .ends_string  (s1_ends_r),
    .res          (res)
  );

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    if (s1_adv && s1_ends_r) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_character;
      s1_none_r <= in_no_character;
      s1_ends_r <= in_ends_string;
    end
    if (s1_adv && s1_ends_r) begin
      res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_is_valid   = res_r.is_valid;
  assign out_address    = res_r.address;
  assign out_is_private = res_r.is_private;

endmodule

// ===== design/ipv4tp_checker.sv =====
// Port-level checks of the IPv4 text parse unit, bound to the top level.
// Depends on ipv4_text_parse_classify_unit_defines.svh.
`timescale 1ns / 1ps
`include "ipv4_text_parse_classify_unit_defines.svh"

module ipv4tp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_character,
  input logic        in_no_character,
  input logic        in_ends_string,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_is_valid,
  input logic [31:0] out_address,
  input logic        out_is_private
);

  `IPV4TP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IPV4TP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_address))
  `IPV4TP_ASSERT_NOW(a_invalid_zero, out_valid && !out_is_valid, out_address == 32'd0 && !out_is_private)
  `IPV4TP_ASSERT_NOW(a_private_valid, out_valid && out_is_private, out_is_valid)

endmodule

bind ipv4_text_parse_classify_unit ipv4tp_checker u_ipv4tp_checker (.*);
